/* src/mie_pkg.sv */
`default_nettype none
package mie_pkg;

    localparam int WIDTH_DEF = 31;
    localparam int QDEPTH_DEF = 48;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_START,
        ST_DIV_RUN,
        ST_DIV_DONE,
        ST_UNW_READ,
        ST_UNW_WAIT,
        ST_MUL_RUN,
        ST_UNW_SUB,
        ST_RESULT
    } mie_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture inputs
        logic div_start; // start serial divide a / b
        logic div_step;  // one quotient bit
        logic push;      // write quotient, shift a,b
        logic unw_init;  // c1 = 1, c2 = 0
        logic mul_start; // start q * c1 mod m
        logic mul_step;
        logic unw_sub;   // c1 = c2 - prod, c2 = c1
        logic set_one;   // result forced to 1
        logic set_fail;  // no inverse
        logic set_ok;    // result from c1
    } mie_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic bad_in;    // modulus < 2 or value == 0
        logic is_one;    // value == 1
        logic b_zero;
        logic div_last;
        logic r_zero;
        logic r_one;
        logic mul_last;
    } mie_stat_t;

endpackage
`default_nettype wire

/* src/modular_inverse_euclid_top.sv */
// channel   signals                          direction
// input     in_valid in_stall modulus value  into block
// output    out_valid out_stall inverse      out of block
//           no_inverse
// one item at a time: each Euclid step runs the serial divider (one
// quotient bit per cycle) and each unwinding step a shift-add modular
// multiply; the 48-entry quotient stack bounds the number of steps.
// reset is asynchronous, active low, and returns the controller to idle.
// the result register holds while out_stall is high; in_stall stays high
// from acceptance until the result beat is taken.
`default_nettype none
module modular_inverse_euclid_top
    import mie_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF,
    parameter int QUOTIENT_DEPTH = QDEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [WIDTH-1:0] modulus,
    input  wire logic [WIDTH-1:0] value,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [WIDTH-1:0]      inverse,
    output logic                  no_inverse
);

    mie_cmd_t  cmd;
    mie_stat_t stat;
    logic      full, empty;

    mie_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall),
        .stat(stat), .full(full), .empty(empty), .cmd(cmd)
    );

    mie_datapath #(.WIDTH(WIDTH), .QUOTIENT_DEPTH(QUOTIENT_DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .modulus(modulus), .value(value),
        .stat(stat), .full(full), .empty(empty),
        .inverse(inverse), .no_inverse(no_inverse)
    );

endmodule
`default_nettype wire

/* src/mie_ram.sv */
`default_nettype none
module mie_ram #(
    parameter int DW = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DW-1:0]            wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DW-1:0]            rdata
);

    logic [DW-1:0] mem [DEPTH];

    // one write, one registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* src/mie_datapath.sv */
`default_nettype none
module mie_datapath
    import mie_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF,
    parameter int QUOTIENT_DEPTH = QDEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mie_cmd_t         cmd,
    input  wire logic [WIDTH-1:0] modulus,
    input  wire logic [WIDTH-1:0] value,
    output mie_stat_t             stat,
    output logic                  full,
    output logic                  empty,
    output logic [WIDTH-1:0]      inverse,
    output logic                  no_inverse
);

    localparam int CW = $clog2(WIDTH + 1);
    localparam int AW = $clog2(QUOTIENT_DEPTH);
    localparam int DW = $clog2(QUOTIENT_DEPTH + 1);

    logic [WIDTH-1:0] m_reg, a_reg, b_reg;
    logic [WIDTH-1:0] q_reg, r_reg;
    logic [CW-1:0]    cnt_reg;
    logic [DW-1:0]    depth_reg;
    logic [WIDTH-1:0] c1_reg, c2_reg;
    logic [WIDTH-1:0] mx_reg, mb_reg, acc_reg;
    logic [WIDTH-1:0] inv_reg;
    logic             fail_reg;
    logic [WIDTH-1:0] qrd;
    logic [WIDTH:0]   trial;
    logic [WIDTH-1:0] r_next_w;
    logic [WIDTH:0]   acc_sum, x_dbl, sub_w;

    // value == 1 is caught here; value == k * modulus + 1 runs the chain
    // and unwinds to 1 on its own
    assign stat.bad_in = (m_reg < WIDTH'(2)) || (b_reg == '0);
    assign stat.b_zero = (b_reg == '0);
    assign stat.div_last = (cnt_reg == CW'(1));
    assign stat.r_zero = (r_next_w == '0);
    assign stat.r_one = (r_next_w == WIDTH'(1));
    assign stat.mul_last = (mb_reg == '0);
    assign stat.is_one = (b_reg == WIDTH'(1));
    assign full = (depth_reg == DW'(QUOTIENT_DEPTH));
    assign empty = (depth_reg == '0);

    // restoring divide: one bit per cycle, dividend shifts out of q_reg
    assign trial = {r_reg, q_reg[WIDTH-1]} - {1'b0, b_reg};
    assign r_next_w = r_reg;

    // modular add helpers for shift-add multiply
    assign acc_sum = {1'b0, acc_reg} + {1'b0, mx_reg};
    assign x_dbl = {1'b0, mx_reg} + {1'b0, mx_reg};
    assign sub_w = (c2_reg >= acc_reg) ? {1'b0, c2_reg - acc_reg}
                                       : {1'b0, c2_reg + (m_reg - acc_reg)};

    mie_ram #(.DW(WIDTH), .DEPTH(QUOTIENT_DEPTH)) u_stack (
        .clk(clk),
        .we(cmd.push),
        .waddr(depth_reg[AW-1:0]),
        .wdata(q_reg),
        .raddr(AW'(depth_reg - DW'(1))),
        .rdata(qrd)
    );

    // control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
            fail_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                depth_reg <= '0;
            end
            else if (cmd.push)
            begin
                depth_reg <= depth_reg + DW'(1);
            end
            else if (cmd.mul_start)
            begin
                depth_reg <= depth_reg - DW'(1);
            end
            if (cmd.div_start)
            begin
                cnt_reg <= CW'(WIDTH);
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
            if (cmd.set_fail)
            begin
                fail_reg <= 1'b1;
            end
            else if (cmd.set_one || cmd.set_ok)
            begin
                fail_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            m_reg <= modulus;
            a_reg <= modulus;
            b_reg <= value;
        end
        if (cmd.div_start)
        begin
            q_reg <= a_reg;
            r_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (!trial[WIDTH])
            begin
                r_reg <= trial[WIDTH-1:0];
                q_reg <= {q_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                r_reg <= {r_reg[WIDTH-2:0], q_reg[WIDTH-1]};
                q_reg <= {q_reg[WIDTH-2:0], 1'b0};
            end
        end
        if (cmd.push)
        begin
            a_reg <= b_reg;
            b_reg <= r_reg;
        end
        if (cmd.unw_init)
        begin
            c1_reg <= WIDTH'(1);
            c2_reg <= '0;
        end
        // c1 is already reduced; the raw quotient drives the bit scan
        if (cmd.mul_start)
        begin
            mx_reg  <= c1_reg;
            mb_reg  <= qrd;
            acc_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            if (mb_reg[0])
            begin
                acc_reg <= (acc_sum >= {1'b0, m_reg}) ? WIDTH'(acc_sum - {1'b0, m_reg})
                                                     : acc_sum[WIDTH-1:0];
            end
            mx_reg <= (x_dbl >= {1'b0, m_reg}) ? WIDTH'(x_dbl - {1'b0, m_reg})
                                               : x_dbl[WIDTH-1:0];
            mb_reg <= mb_reg >> 1;
        end
        if (cmd.unw_sub)
        begin
            c1_reg <= sub_w[WIDTH-1:0];
            c2_reg <= c1_reg;
        end
        if (cmd.set_one)
        begin
            inv_reg <= WIDTH'(1);
        end
        else if (cmd.set_fail)
        begin
            inv_reg <= '0;
        end
        else if (cmd.set_ok)
        begin
            inv_reg <= c1_reg;
        end
    end

    assign inverse = inv_reg;
    assign no_inverse = fail_reg;

endmodule
`default_nettype wire

/* src/mie_ctrl.sv */
`default_nettype none
module mie_ctrl
    import mie_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  wire logic      out_stall,
    input  wire mie_stat_t stat,
    input  wire logic      full,
    input  wire logic      empty,
    output mie_cmd_t       cmd
);

    mie_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_stall = 1'b1;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.bad_in)
                begin
                    cmd.set_fail = 1'b1;
                    state_next = ST_RESULT;
                end
                else if (stat.is_one)
                begin
                    cmd.set_one = 1'b1;
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_DIV_START;
                end
            end
            ST_DIV_START:
            begin
                if (stat.b_zero || full)
                begin
                    cmd.set_fail = 1'b1;
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next = ST_DIV_RUN;
                end
            end
            ST_DIV_RUN:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_DIV_DONE;
                end
            end
            ST_DIV_DONE:
            begin
                cmd.push = 1'b1;
                if (stat.r_zero)
                begin
                    cmd.set_fail = 1'b1;
                    state_next = ST_RESULT;
                end
                else if (stat.r_one)
                begin
                    cmd.unw_init = 1'b1;
                    state_next = ST_UNW_READ;
                end
                else
                begin
                    state_next = ST_DIV_START;
                end
            end
            ST_UNW_READ:
            begin
                if (empty)
                begin
                    cmd.set_ok = 1'b1;
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_UNW_WAIT;
                end
            end
            ST_UNW_WAIT:
            begin
                cmd.mul_start = 1'b1;
                state_next = ST_MUL_RUN;
            end
            ST_MUL_RUN:
            begin
                if (stat.mul_last)
                begin
                    state_next = ST_UNW_SUB;
                end
                else
                begin
                    cmd.mul_step = 1'b1;
                end
            end
            ST_UNW_SUB:
            begin
                cmd.unw_sub = 1'b1;
                state_next = ST_UNW_READ;
            end
            ST_RESULT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* src/mie_checker.sv */
`default_nettype none
module mie_checker #(
    parameter int WIDTH = 31
) (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_stall,
    input wire logic             out_valid,
    input wire logic             out_stall,
    input wire logic [WIDTH-1:0] inverse,
    input wire logic             no_inverse
);

    // no input taken while a result waits
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input taken during result");

    // accepted item blocks input next cycle
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (in_stall && !out_valid))
        else $error("accept not followed by busy");

    // failure result carries zero
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && no_inverse) |-> (inverse == '0))
        else $error("nonzero inverse with flag");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(inverse)))
        else $error("result changed under stall");

endmodule

bind modular_inverse_euclid_top mie_checker #(.WIDTH(WIDTH)) u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .inverse(inverse), .no_inverse(no_inverse)
);
`default_nettype wire
